// ----- rtl/ppap_pkg.sv -----
// shared types and constants of the ascii ppm pixel parser
`default_nettype none

package ppap_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // byte codes the parser cares about
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [15:0] LEVEL_SAT = 16'hFFFF;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_BLANK,
    CLS_NEWLINE,
    CLS_HASH,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_HEADER,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] img_width;
    logic [12:0] img_height;
    logic [15:0] max_level;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } out_item_t;

  // classified byte passed from front to back
  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       file_start;
    logic       file_end;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/ppap_front.sv -----
// front stage: takes bytes and classifies them into tokens
`default_nettype none

module ppap_front
  import ppap_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          tok_valid,
  output tok_t          tok_data,
  input  wire logic     tok_full
);

  logic tok_valid_r;
  tok_t tok_r;
  tok_t tok_nxt;
  logic [7:0] dig_byte;

  assign dig_byte = in_data.char_in - CH_ZERO;

  always_comb begin
    tok_nxt.digit      = dig_byte[3:0];
    tok_nxt.file_start = in_data.file_start;
    tok_nxt.file_end   = in_data.file_end;
    if (in_data.char_in >= CH_ZERO && in_data.char_in <= CH_NINE) begin
      tok_nxt.cls = CLS_DIGIT;
    end else if (in_data.char_in == CH_LF) begin
      tok_nxt.cls = CLS_NEWLINE;
    end else if (in_data.char_in == CH_SPACE || in_data.char_in == CH_TAB ||
                 in_data.char_in == CH_CR) begin
      tok_nxt.cls = CLS_BLANK;
    end else if (in_data.char_in == CH_HASH) begin
      tok_nxt.cls = CLS_HASH;
    end else begin
      tok_nxt.cls = CLS_OTHER;
    end
  end

  assign in_stall  = tok_valid_r && tok_full;
  assign tok_valid = tok_valid_r;
  assign tok_data  = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (!in_stall) begin
      tok_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppap_queue.sv -----
// two-entry token queue between front and back
`default_nettype none

module ppap_queue
  import ppap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire tok_t push_data,
  output logic      full,
  output logic      pop_valid,
  output tok_t      pop_data,
  input  wire logic pop
);

  tok_t       mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = mem[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppap_back.sv -----
// back stage: number parsing, header and pixel sequencing, result register
`default_nettype none

module ppap_back
  import ppap_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  tok_valid,
  input  wire tok_t  tok_data,
  output logic       tok_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);

  localparam logic [16:0] MaxDimC = 17'(MAX_DIM);

  // state registers
  phase_t      phase_r, phase_nxt;
  logic        in_comment_r, in_comment_nxt;
  logic        in_number_r, in_number_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [12:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [15:0] maxval_r, maxval_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic        out_valid_r;
  out_item_t   out_r;

  // state as seen by this token (file start resets first)
  phase_t      ph_e;
  logic        cmt_e, num_e, ovf_e;
  logic [15:0] acc_e;
  logic [1:0]  fidx_e;
  logic [12:0] w_e, h_e;
  logic [15:0] mv_e;
  logic [11:0] col_e, row_e;

  logic        take;
  logic        active, open_text;
  logic        is_digit, is_sep, is_hash, is_bad;
  logic [19:0] acc_x10;
  logic [15:0] dig_acc;
  logic        dig_ovf;
  logic        fin;
  logic [15:0] fin_acc, sat;
  logic        fin_ovf, big, dim_bad;
  logic        hdr_dim, hdr_done, pix, pix_out;
  logic        end_col, end_row, last_pix;
  logic        err;
  logic        res_v;
  out_item_t   res;

  assign take    = !out_valid_r || !out_stall;
  assign tok_pop = take;

  always_comb begin
    if (tok_data.file_start) begin
      ph_e   = PH_SKIP;
      cmt_e  = 1'b0;
      num_e  = 1'b0;
      acc_e  = '0;
      ovf_e  = 1'b0;
      fidx_e = '0;
      w_e    = '0;
      h_e    = '0;
      mv_e   = '0;
      col_e  = '0;
      row_e  = '0;
    end else begin
      ph_e   = phase_r;
      cmt_e  = in_comment_r;
      num_e  = in_number_r;
      acc_e  = acc_r;
      ovf_e  = ovf_r;
      fidx_e = fidx_r;
      w_e    = width_r;
      h_e    = height_r;
      mv_e   = maxval_r;
      col_e  = col_r;
      row_e  = row_r;
    end
  end

  // token decode and number completion
  always_comb begin
    active    = (ph_e == PH_HEADER) || (ph_e == PH_PIXELS);
    open_text = active && !cmt_e;
    is_digit  = open_text && (tok_data.cls == CLS_DIGIT);
    is_sep    = open_text && ((tok_data.cls == CLS_BLANK) ||
                              (tok_data.cls == CLS_NEWLINE));
    is_hash   = open_text && (tok_data.cls == CLS_HASH);
    is_bad    = open_text && (tok_data.cls == CLS_OTHER);

    // times ten by shift and add
    acc_x10 = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0} + {16'd0, tok_data.digit};
    if (num_e) begin
      dig_acc = acc_x10[15:0];
      dig_ovf = ovf_e || (acc_x10[19:16] != 4'd0);
    end else begin
      dig_acc = {12'd0, tok_data.digit};
      dig_ovf = 1'b0;
    end

    fin     = ((is_sep || is_hash) && num_e) || (is_digit && tok_data.file_end);
    fin_acc = is_digit ? dig_acc : acc_e;
    fin_ovf = is_digit ? dig_ovf : ovf_e;
    sat     = fin_ovf ? LEVEL_SAT : fin_acc;
    big     = fin_ovf || ({1'b0, fin_acc} > MaxDimC);
    dim_bad = (sat == 16'd0) || big;

    hdr_dim  = fin && (ph_e == PH_HEADER) && (fidx_e != 2'd2);
    hdr_done = fin && (ph_e == PH_HEADER) && (fidx_e == 2'd2);
    pix      = fin && (ph_e == PH_PIXELS);
    pix_out  = pix && (fidx_e == 2'd2);

    end_col  = ({1'b0, col_e} + 13'd1) >= w_e;
    end_row  = ({1'b0, row_e} + 13'd1) >= h_e;
    last_pix = pix_out && end_col && end_row;

    err = is_bad || (hdr_dim && dim_bad);
  end

  // phase sequencing
  always_comb begin
    unique case (ph_e)
      PH_SKIP:   phase_nxt = (tok_data.cls == CLS_NEWLINE) ? PH_HEADER : PH_SKIP;
      PH_HEADER: begin
        if (err) begin
          phase_nxt = PH_ERROR;
        end else if (hdr_done) begin
          phase_nxt = PH_PIXELS;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_PIXELS: begin
        if (err) begin
          phase_nxt = PH_ERROR;
        end else if (last_pix) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_DONE:   phase_nxt = PH_DONE;
      PH_ERROR:  phase_nxt = PH_ERROR;
      default:   phase_nxt = PH_ERROR;
    endcase
  end

  // datapath next values and result
  always_comb begin
    in_comment_nxt = cmt_e;
    in_number_nxt  = num_e;
    acc_nxt        = acc_e;
    ovf_nxt        = ovf_e;
    fidx_nxt       = fidx_e;
    width_nxt      = w_e;
    height_nxt     = h_e;
    maxval_nxt     = mv_e;
    red_nxt        = red_r;
    green_nxt      = green_r;
    col_nxt        = col_e;
    row_nxt        = row_e;
    if (tok_data.file_start) begin
      red_nxt   = '0;
      green_nxt = '0;
    end

    if (active && cmt_e && (tok_data.cls == CLS_NEWLINE)) begin
      in_comment_nxt = 1'b0;
    end
    if (is_hash && !err && !last_pix) begin
      in_comment_nxt = 1'b1;
    end
    if (is_digit) begin
      acc_nxt       = dig_acc;
      ovf_nxt       = dig_ovf;
      in_number_nxt = 1'b1;
    end
    if (fin) begin
      in_number_nxt = 1'b0;
    end
    if (err) begin
      in_number_nxt  = 1'b0;
      in_comment_nxt = 1'b0;
    end

    if (hdr_dim && !dim_bad) begin
      fidx_nxt = fidx_e + 2'd1;
      if (fidx_e == 2'd0) begin
        width_nxt = sat[12:0];
      end else begin
        height_nxt = sat[12:0];
      end
    end
    if (hdr_done) begin
      maxval_nxt = sat;
      fidx_nxt   = 2'd0;
      col_nxt    = '0;
      row_nxt    = '0;
    end
    if (pix) begin
      case (fidx_e)
        2'd0:    begin
          red_nxt  = fin_acc[7:0];
          fidx_nxt = 2'd1;
        end
        2'd1:    begin
          green_nxt = fin_acc[7:0];
          fidx_nxt  = 2'd2;
        end
        default: fidx_nxt = 2'd0;
      endcase
    end
    if (pix_out && !last_pix) begin
      if (end_col) begin
        col_nxt = '0;
        row_nxt = row_e + 12'd1;
      end else begin
        col_nxt = col_e + 12'd1;
      end
    end

    res   = '0;
    res_v = err || hdr_done || pix_out;
    if (err) begin
      res.kind = KIND_ERROR;
    end else if (hdr_done) begin
      res.kind       = KIND_HEADER;
      res.img_width  = w_e;
      res.img_height = h_e;
      res.max_level  = sat;
    end else if (pix_out) begin
      res.kind       = KIND_PIXEL;
      res.img_width  = w_e;
      res.img_height = h_e;
      res.max_level  = mv_e;
      res.red        = red_r & {8{!tok_data.file_start}};
      res.green      = green_r & {8{!tok_data.file_start}};
      res.blue       = fin_acc[7:0];
      res.column     = col_e;
      res.row        = row_e;
      res.last       = last_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SKIP;
      in_comment_r <= 1'b0;
      in_number_r  <= 1'b0;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
      fidx_r       <= '0;
      width_r      <= '0;
      height_r     <= '0;
      maxval_r     <= '0;
      red_r        <= '0;
      green_r      <= '0;
      col_r        <= '0;
      row_r        <= '0;
    end else if (tok_valid && take) begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      in_number_r  <= in_number_nxt;
      acc_r        <= acc_nxt;
      ovf_r        <= ovf_nxt;
      fidx_r       <= fidx_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      maxval_r     <= maxval_nxt;
      red_r        <= red_nxt;
      green_r      <= green_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= tok_valid && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok_valid && res_v) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/ppm_ascii_pixel_parser.sv -----
// top level of the ascii ppm (p3) pixel parser
// path: a byte passes the front token register, the queue and the back result register
// throughput: one byte per cycle while out_stall is low; the back stage takes one
// token per cycle, gated only by the output register
// reset: synchronous active-low rst_n empties the pipeline and queue and puts the
// parser in its skip-first-line phase; file_start does the same for the parse state
`default_nettype none

module ppm_ascii_pixel_parser
  import ppap_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // front register to queue
  logic tok_valid;
  tok_t tok_data;
  logic q_full;

  // queue to back stage
  logic q_valid;
  tok_t q_data;
  logic q_pop;

  // front: registers each transfer and classifies the byte
  // (digit, blank, newline, hash or anything else)
  ppap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .tok_valid (tok_valid),
    .tok_data  (tok_data),
    .tok_full  (q_full)
  );

  // short queue so the front keeps taking bytes while a result waits
  ppap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (tok_valid),
    .push_data  (tok_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  // back: decimal accumulation, header fields, pixel triples with
  // column/row counting, and the registered result
  ppap_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok_data  (q_data),
    .tok_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/ppap_checker.sv -----
// port-level checker for the ppm parser and its bind
`default_nettype none

module ppap_checker
  import ppap_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // after reset no result is offered
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a header carries nonzero dimensions and no pixel data
  a_header_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_HEADER |->
      out_data.img_width != 13'd0 && out_data.img_height != 13'd0 &&
      out_data.last == 1'b0)
    else $error("bad header result");

  // the last pixel sits at the bottom right corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PIXEL && out_data.last |->
      ({1'b0, out_data.column} + 13'd1) >= out_data.img_width &&
      ({1'b0, out_data.row} + 13'd1) >= out_data.img_height)
    else $error("last pixel not at image corner");

  // an error result carries nothing but its kind
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERROR |->
      out_data.img_width == 13'd0 && out_data.max_level == 16'd0 &&
      out_data.last == 1'b0 && out_data.column == 12'd0)
    else $error("error result carries data");

endmodule

bind ppm_ascii_pixel_parser ppap_checker u_ppap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the ascii ppm pixel parser, fed with directed and random p3 files

module tb;
  import ppap_pkg::*;

  localparam int MAX_DIM      = 4096;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int PHASE_BYTES  = 360;   // least bytes sent per idling mix, four mixes
  localparam int DRAIN_CYCLES = 12;    // pipeline is front register, queue and result register, leave some margin
  localparam int MAX_REPORTS  = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ppm_ascii_pixel_parser #(.MAX_DIM(MAX_DIM)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // idling knobs, percent per cycle; stray_end_pct is per byte
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int stray_end_pct = 0;

  // run bookkeeping
  int fail_count   = 0;
  int bytes_sent   = 0;
  int live_bytes   = 0;
  int files_sent   = 0;
  int header_count = 0;
  int pixel_count  = 0;
  int error_count  = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // behavioral parser: state of the file being read and the records it owes
  // ---------------------------------------------------------------------------
  phase_t      parse_phase;
  bit          in_comment_q;
  bit          in_number_q;
  bit          number_ovf;
  logic [15:0] number_acc;
  logic [1:0]  field_sel;
  logic [12:0] image_w;
  logic [12:0] image_h;
  logic [15:0] image_max;
  logic [7:0]  red_keep;
  logic [7:0]  green_keep;
  logic [11:0] next_col;
  logic [11:0] next_row;
  out_item_t   records_due[$];

  // text of the file under construction
  logic [7:0]  file_text[$];

  task automatic parse_reset();
    parse_phase  = PH_SKIP;
    in_comment_q = 1'b0;
    in_number_q  = 1'b0;
    number_ovf   = 1'b0;
    number_acc   = '0;
    field_sel    = '0;
    image_w      = '0;
    image_h      = '0;
    image_max    = '0;
    red_keep     = '0;
    green_keep   = '0;
    next_col     = '0;
    next_row     = '0;
  endtask

  // format error: only kind is set, parser goes deaf until the next file
  task automatic flag_error(output bit made, output out_item_t rec);
    rec          = '0;
    rec.kind     = KIND_ERROR;
    parse_phase  = PH_ERROR;
    in_number_q  = 1'b0;
    in_comment_q = 1'b0;
    made         = 1'b1;
  endtask

  // a decimal number just closed: header field or pixel component
  task automatic end_number(output bit made, output out_item_t rec);
    logic [15:0] sat;
    bit          too_big;
    bit          end_col;
    bit          end_row;
    made        = 1'b0;
    rec         = '0;
    sat         = number_ovf ? LEVEL_SAT : number_acc;
    too_big     = number_ovf || (number_acc > MAX_DIM);
    in_number_q = 1'b0;
    if (parse_phase == PH_HEADER) begin
      if (field_sel != 2'd2) begin
        // width or height: zero and oversize are rejected
        if (sat == 0 || too_big) begin
          flag_error(made, rec);
        end else begin
          if (field_sel == 2'd0) image_w = sat[12:0];
          else image_h = sat[12:0];
          field_sel++;
        end
      end else begin
        image_max      = sat;
        field_sel      = 2'd0;
        next_col       = '0;
        next_row       = '0;
        parse_phase    = PH_PIXELS;
        rec.kind       = KIND_HEADER;
        rec.img_width  = image_w;
        rec.img_height = image_h;
        rec.max_level  = image_max;
        made           = 1'b1;
      end
    end else if (parse_phase == PH_PIXELS) begin
      case (field_sel)
        2'd0: begin
          red_keep  = number_acc[7:0];
          field_sel = 2'd1;
        end
        2'd1: begin
          green_keep = number_acc[7:0];
          field_sel  = 2'd2;
        end
        default: begin
          field_sel      = 2'd0;
          end_col        = (int'(next_col) + 1) >= int'(image_w);
          end_row        = (int'(next_row) + 1) >= int'(image_h);
          rec.kind       = KIND_PIXEL;
          rec.img_width  = image_w;
          rec.img_height = image_h;
          rec.max_level  = image_max;
          rec.red        = red_keep;
          rec.green      = green_keep;
          rec.blue       = number_acc[7:0];
          rec.column     = next_col;
          rec.row        = next_row;
          rec.last       = end_col && end_row;
          made           = 1'b1;
          // raster order, the final pixel closes the image
          if (end_col && end_row) begin
            parse_phase = PH_DONE;
          end else if (end_col) begin
            next_col = '0;
            next_row = next_row + 1'b1;
          end else begin
            next_col = next_col + 1'b1;
          end
        end
      endcase
    end
  endtask

  // one accepted byte; live tells whether the parser was still listening
  task automatic parse_byte(input in_item_t item, output bit live);
    logic [7:0] ch;
    bit         made;
    out_item_t  rec;
    int         digit_val;
    int         wide;
    ch   = item.char_in;
    made = 1'b0;
    rec  = '0;
    if (item.file_start) parse_reset();
    live = (parse_phase != PH_DONE && parse_phase != PH_ERROR);
    if (parse_phase == PH_SKIP) begin
      // magic line is not looked at
      if (ch == CH_LF) parse_phase = PH_HEADER;
    end else if (live) begin
      if (in_comment_q) begin
        if (ch == CH_LF) in_comment_q = 1'b0;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        digit_val = int'(ch) - int'(CH_ZERO);
        if (!in_number_q) begin
          in_number_q = 1'b1;
          number_acc  = 16'(digit_val);
          number_ovf  = 1'b0;
        end else begin
          wide = int'(number_acc) * 10 + digit_val;
          if (wide > 65535) number_ovf = 1'b1;
          number_acc = wide[15:0];
        end
      end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF) begin
        if (in_number_q) end_number(made, rec);
      end else if (ch == CH_HASH) begin
        // a hash right after digits closes the number first
        if (in_number_q) end_number(made, rec);
        if (parse_phase == PH_HEADER || parse_phase == PH_PIXELS) in_comment_q = 1'b1;
      end else begin
        flag_error(made, rec);
      end
      // end of file closes a number still open
      if (item.file_end && in_number_q && !made) end_number(made, rec);
    end
    if (made) records_due.push_back(rec);
  endtask

  // ---------------------------------------------------------------------------
  // input side: one byte per call, entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] ch, input bit starts, input bit ends);
    in_item_t item;
    bit       live;
    item.char_in    = ch;
    item.file_start = starts;
    item.file_end   = ends;
    // random gap before the transfer; valid only drops here, never next to a raise
    while (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    parse_byte(item, live);
    bytes_sent++;
    if (live) live_bytes++;
    @(negedge clk);
  endtask

  task automatic send_file(input bit mark_start, input bit mark_end);
    bit ends;
    for (int i = 0; i < file_text.size(); i++) begin
      ends = (mark_end && i == file_text.size() - 1) ||
             ($urandom_range(0, 99) < stray_end_pct);
      send_byte(file_text[i], mark_start && i == 0, ends);
    end
    if (mark_start) files_sent++;
  endtask

  task automatic load_text(input string s);
    file_text.delete();
    for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
  endtask

  // ---------------------------------------------------------------------------
  // random file pieces
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LF) ? 8'h00 : b;
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 86) return $urandom_range(1, 3);
    if (roll < 90) return 0;
    if (roll < 94) return MAX_DIM;
    if (roll < 97) return $urandom_range(MAX_DIM + 1, 65535);
    return $urandom_range(65536, 999999);
  endfunction

  // color level: mostly in byte range, some wide and some past 16 bits
  function automatic int unsigned pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 255);
    if (roll < 93) return $urandom_range(256, 65535);
    return $urandom_range(65536, 9999999);
  endfunction

  task automatic put_number(input int unsigned value);
    string digits;
    // occasional leading zeros
    repeat ($urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0) file_text.push_back(CH_ZERO);
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) file_text.push_back(digits[i]);
  endtask

  task automatic put_gap();
    int pick;
    repeat ($urandom_range(1, 2)) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: file_text.push_back(CH_SPACE);
        4: file_text.push_back(CH_TAB);
        5: file_text.push_back(CH_CR);
        6, 7: file_text.push_back(CH_LF);
        default: begin
          // comment with arbitrary bytes up to the line end
          file_text.push_back(CH_HASH);
          repeat ($urandom_range(0, 4)) file_text.push_back(any_but_lf());
          file_text.push_back(CH_LF);
        end
      endcase
    end
  endtask

  // mostly well-formed small images; some bad sizes, truncation, stray bytes
  task automatic random_file();
    int unsigned w;
    int unsigned h;
    int unsigned pixels;
    int          body_start;
    file_text.delete();
    repeat ($urandom_range(0, 5)) file_text.push_back(any_but_lf());
    if ($urandom_range(0, 49) != 0) file_text.push_back(CH_LF);
    body_start = file_text.size();
    w = pick_dim();
    h = pick_dim();
    if ($urandom_range(0, 3) == 0) put_gap();
    put_number(w);
    put_gap();
    put_number(h);
    put_gap();
    put_number(pick_level());
    put_gap();
    pixels = (w <= 4 && h <= 4) ? w * h : $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) pixels = $urandom_range(0, pixels);
    for (int p = 0; p < int'(pixels); p++) begin
      for (int c = 0; c < 3; c++) begin
        put_number(pick_level());
        // the very last number may rely on file end to close it
        if (p < int'(pixels) - 1 || c < 2 || $urandom_range(0, 1) == 1) put_gap();
      end
    end
    // junk past the image
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) file_text.push_back(8'($urandom_range(0, 255)));
    end
    // corrupt one byte of the body now and then
    if ($urandom_range(0, 11) == 0 && file_text.size() > body_start) begin
      file_text[$urandom_range(body_start, file_text.size() - 1)] = 8'($urandom_range(0, 255));
    end
    send_file(1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // file ended after the width keeps its state; the rest arrives as a
  // continuation: hash after digits, comment, saturated max level, tab, cr,
  // component wrap to 8 bits, file end closing the last number, then one
  // byte past the final pixel that must be ignored
  task automatic test_split_image();
    load_text("\n1");
    send_file(1'b1, 1'b1);
    load_text(" 1#\n70000 256\t0\r300");
    send_file(1'b0, 1'b1);
    load_text("x");
    send_file(1'b0, 1'b0);
  endtask

  task automatic test_zero_width();
    load_text("\n0 ");
    send_file(1'b1, 1'b1);
  endtask

  // bytes 255 and 0: the first is rejected, the second falls on a dead parser
  task automatic test_bad_bytes();
    file_text.delete();
    file_text.push_back(CH_LF);
    file_text.push_back(8'hFF);
    file_text.push_back(8'h00);
    send_file(1'b1, 1'b1);
  endtask

  task automatic test_random_files(input int budget);
    int start_count;
    start_count   = bytes_sent;
    stray_end_pct = 2;
    while (bytes_sent - start_count < budget) random_file();
    stray_end_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stall, redrawn every falling edge
  always @(negedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(0, 99) < out_stall_pct);
  end

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  out_item_t due_rec;

  // every result transfer is matched against the oldest owed record
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (records_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual kind %0d",
                   $time, out_data.kind);
      end else begin
        due_rec = records_due.pop_front();
        compare_field("kind", due_rec.kind, out_data.kind);
        compare_field("img_width", due_rec.img_width, out_data.img_width);
        compare_field("img_height", due_rec.img_height, out_data.img_height);
        compare_field("max_level", due_rec.max_level, out_data.max_level);
        compare_field("red", due_rec.red, out_data.red);
        compare_field("green", due_rec.green, out_data.green);
        compare_field("blue", due_rec.blue, out_data.blue);
        compare_field("column", due_rec.column, out_data.column);
        compare_field("row", due_rec.row, out_data.row);
        compare_field("last", due_rec.last, out_data.last);
        case (due_rec.kind)
          KIND_HEADER: header_count++;
          KIND_PIXEL:  pixel_count++;
          default:     error_count++;
        endcase
      end
    end
  end

  // watchdog: too long without any transfer means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    parse_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_split_image();
    test_zero_width();
    test_bad_bytes();

    // back to back on both sides
    in_gap_pct    = 0;
    out_stall_pct = 0;
    test_random_files(PHASE_BYTES);
    // sparse sender
    in_gap_pct    = 81;
    out_stall_pct = 0;
    test_random_files(PHASE_BYTES);
    // heavy back-pressure
    in_gap_pct    = 0;
    out_stall_pct = 81;
    test_random_files(PHASE_BYTES);
    // light idling on both sides
    in_gap_pct    = 19;
    out_stall_pct = 19;
    test_random_files(PHASE_BYTES);

    // drain: everything owed must come out, then a quiet tail
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d files, %0d bytes (%0d reaching a live parser), four idling mixes",
             files_sent, bytes_sent, live_bytes);
    $display("checked %0d headers, %0d pixels and %0d format errors",
             header_count, pixel_count, error_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ppap_pkg.sv
rtl/ppap_front.sv
rtl/ppap_queue.sv
rtl/ppap_back.sv
rtl/ppm_ascii_pixel_parser.sv
rtl/ppap_checker.sv
dv/tb.sv
